[rtl/lottery_sum_tree_scheduler_core_defines.svh]
// Assertion macros shared by the lottery scheduler RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef LOTTERY_SUM_TREE_SCHEDULER_CORE_DEFINES_SVH
`define LOTTERY_SUM_TREE_SCHEDULER_CORE_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define LSTS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("lsts assertion failed");

// Check that a condition implies another one on the following edge.
`define LSTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsts assertion failed");

`endif

[rtl/lsts_pkg.sv]
// Shared types and constants of the lottery scheduler.
// No dependencies.
`default_nettype none
package lsts_pkg;

    localparam int CAPACITY    = 16;
    localparam int TICKET_BITS = 16;
    localparam int ID_BITS     = 16;
    localparam int DRAW_W      = 20;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_MODIFY = 2'd2,
        K_ALLOC  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_TICKETS = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_NO_CLIENTS  = 3'd5,
        ST_DRAW_LARGE  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]             kind;
        logic [ID_BITS-1:0]     client_id;
        logic [TICKET_BITS-1:0] tickets;
        logic [DRAW_W-1:0]      draw;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [ID_BITS-1:0] winner_id;
        logic [DRAW_W-1:0]  root_sum;
    } t_out_item;

    // Token travelling along the cell row during an allocate
    typedef struct packed {
        logic               active;
        logic               done;
        logic [DRAW_W-1:0]  acc;
        logic [ID_BITS-1:0] winner;
    } t_wave;

    typedef struct packed {
        logic                   en;
        logic                   used;
        logic [ID_BITS-1:0]     owner;
        logic [TICKET_BITS-1:0] tickets;
    } t_cell_wr;

    typedef struct packed {
        logic                   used;
        logic [ID_BITS-1:0]     owner;
        logic [TICKET_BITS-1:0] tickets;
    } t_cell_view;

endpackage
`default_nettype wire

[rtl/lsts_cell.sv]
// One client slot of the lottery scheduler: owner, tickets, used flag and
// one stage of the allocate wave. Depends on lsts_pkg.
`default_nettype none
module lsts_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lsts_pkg::DRAW_W-1:0] i_draw,
    input  lsts_pkg::t_wave             i_wave,
    input  lsts_pkg::t_cell_wr          i_wr,
    output lsts_pkg::t_wave             o_wave,
    output lsts_pkg::t_cell_view        o_view
);
    import lsts_pkg::*;

    logic                   r_used;
    logic [ID_BITS-1:0]     r_owner;
    logic [TICKET_BITS-1:0] r_tickets;
    t_wave                  r_wave;
    t_wave                  n_wave;
    logic [DRAW_W-1:0]      acc_out;
    logic                   hit;

    assign acc_out = i_wave.acc + DRAW_W'(r_tickets);
    assign hit     = i_wave.active && !i_wave.done && r_used && (i_draw < acc_out);

    always_comb begin
        n_wave.active = i_wave.active;
        n_wave.done   = i_wave.done || hit;
        n_wave.acc    = acc_out;
        n_wave.winner = hit ? r_owner : i_wave.winner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_tickets <= '0;
        end else if (i_wr.en) begin
            r_used    <= i_wr.used;
            r_tickets <= i_wr.tickets;
        end
    end

    // Owner is payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_owner <= i_wr.owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave         = r_wave;
    assign o_view.used    = r_used;
    assign o_view.owner   = r_owner;
    assign o_view.tickets = r_tickets;

endmodule
`default_nettype wire

[rtl/lottery_sum_tree_scheduler_core.sv]
// Top level of the weighted lottery scheduler: control, running total and
// the row of slot cells. Depends on lsts_pkg, lsts_cell and the defines header.
//
// Weighted lottery scheduler over CAPACITY client slots. Each input transfer
// carries one command: add a client with a ticket count, remove a client,
// change a client's tickets, or allocate with a draw supplied by the user.
// Every command yields exactly one result transfer with a status code, the
// winning client id (zero unless an allocate succeeds) and the total ticket
// count after the command. Add, remove and modify go from acceptance through
// the execute and finish states to the result register: the slot search is a
// parallel compare across all cells and the total is kept as a running sum.
// An allocate walks a token along the row of slot cells one cell per cycle,
// accumulating tickets, and records the first slot whose cumulative count
// exceeds the draw. One command is in flight at a time; a new one is taken
// while the previous result still waits in the output register.
`default_nettype none
`include "lottery_sum_tree_scheduler_core_defines.svh"
module lottery_sum_tree_scheduler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lsts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lsts_pkg::t_out_item o_out_data
);
    import lsts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_in_item            r_item;
    logic [DRAW_W-1:0]   r_total;
    logic [DRAW_W-1:0]   n_total;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    t_out_item           r_fin;
    t_out_item           n_fin;
    t_out_item           r_out;
    logic                r_out_valid;

    t_wave               wave [CAPACITY+1];
    t_cell_wr            wr   [CAPACITY];
    t_cell_view          view [CAPACITY];

    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] free_vec;
    logic [CAPACITY-1:0] first_free;
    logic [TICKET_BITS-1:0] old_tickets;
    logic                any_match;
    logic                tickets_ok;
    logic                in_xfer;
    logic                fin_load;
    logic                alloc_go;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign fin_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // Parallel slot search across the row
    always_comb begin
        old_tickets = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i] = view[i].used && (view[i].owner == r_item.client_id);
            free_vec[i]  = !view[i].used;
            if (match_vec[i]) begin
                old_tickets = old_tickets | view[i].tickets;
            end
        end
    end

    assign any_match  = |match_vec;
    assign first_free = free_vec & (~free_vec + CAPACITY'(1));
    assign tickets_ok = (r_item.tickets != '0);

    // Execute the command: decide status, slot writes and the new total
    always_comb begin
        n_total  = r_total;
        n_count  = r_count;
        n_fin    = r_fin;
        n_state  = r_state;
        alloc_go = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            wr[i].en      = 1'b0;
            wr[i].used    = 1'b0;
            wr[i].owner   = r_item.client_id;
            wr[i].tickets = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_fin.status    = ST_OK;
                n_fin.winner_id = '0;
                n_state         = S_FIN;
                case (t_kind'(r_item.kind))
                    K_ADD: begin
                        if (!tickets_ok) begin
                            n_fin.status = ST_BAD_TICKETS;
                        end else if (any_match) begin
                            n_fin.status = ST_DUPLICATE;
                        end else if (first_free == '0) begin
                            n_fin.status = ST_FULL;
                        end else begin
                            for (int i = 0; i < CAPACITY; i++) begin
                                if (first_free[i]) begin
                                    wr[i].en      = 1'b1;
                                    wr[i].used    = 1'b1;
                                    wr[i].tickets = r_item.tickets;
                                end
                            end
                            n_count = r_count + COUNT_W'(1);
                            n_total = r_total + DRAW_W'(r_item.tickets);
                        end
                    end
                    K_REMOVE: begin
                        if (!any_match) begin
                            n_fin.status = ST_NOT_FOUND;
                        end else begin
                            for (int i = 0; i < CAPACITY; i++) begin
                                if (match_vec[i]) begin
                                    wr[i].en    = 1'b1;
                                    wr[i].owner = view[i].owner;
                                end
                            end
                            n_count = r_count - COUNT_W'(1);
                            n_total = r_total - DRAW_W'(old_tickets);
                        end
                    end
                    K_MODIFY: begin
                        if (!tickets_ok) begin
                            n_fin.status = ST_BAD_TICKETS;
                        end else if (!any_match) begin
                            n_fin.status = ST_NOT_FOUND;
                        end else begin
                            for (int i = 0; i < CAPACITY; i++) begin
                                if (match_vec[i]) begin
                                    wr[i].en      = 1'b1;
                                    wr[i].used    = 1'b1;
                                    wr[i].owner   = view[i].owner;
                                    wr[i].tickets = r_item.tickets;
                                end
                            end
                            n_total = r_total - DRAW_W'(old_tickets)
                                      + DRAW_W'(r_item.tickets);
                        end
                    end
                    K_ALLOC: begin
                        if (r_count == '0) begin
                            n_fin.status = ST_NO_CLIENTS;
                        end else if (r_item.draw >= r_total) begin
                            n_fin.status = ST_DRAW_LARGE;
                        end else begin
                            alloc_go = 1'b1;
                            n_state  = S_WALK;
                        end
                    end
                    default: begin
                        n_fin.status = ST_OK;
                    end
                endcase
                n_fin.root_sum = n_total;
            end
            S_WALK: begin
                // Hold until the token leaves the last cell
                if (wave[CAPACITY].active) begin
                    n_fin.winner_id = wave[CAPACITY].winner;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Inject the token at the head of the row
    assign wave[0] = '{active: alloc_go, done: 1'b0, acc: '0, winner: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lsts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_draw  (r_item.draw),
            .i_wave  (wave[g]),
            .i_wr    (wr[g]),
            .o_wave  (wave[g+1]),
            .o_view  (view[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_count <= n_count;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        r_fin <= n_fin;
        if (fin_load) begin
            r_out <= r_fin;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LSTS_ASSERT_ALWAYS(a_count_range, r_count <= COUNT_W'(CAPACITY))
    `LSTS_ASSERT_ALWAYS(a_wave_in_walk, !wave[CAPACITY].active || r_state == S_WALK)
    `LSTS_ASSERT_NEXT(a_accept_exec, in_xfer, r_state == S_EXEC)
    `LSTS_ASSERT_ALWAYS(a_count_total, r_count != '0 || r_total == '0)

endmodule
`default_nettype wire
